/* hw/rtl/msr_pkg.sv */
`timescale 1ns / 1ps

package msr_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int ID_W         = 6;
   localparam int SLOT_W       = 6;
   localparam int CNT_W        = 7;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 3;

   localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE     = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_AT  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_MEMBER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PICK_RANGE = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] element_id;
      logic [SLOT_W-1:0] pick_slot;
   } msr_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0] removed_id;
      logic [SLOT_W-1:0] assigned_slot;
      logic [CNT_W-1:0] member_count;
   } msr_result_type;

   // one write per table per beat
   typedef struct packed {
      logic sm_we;
      logic [SLOT_W-1:0] sm_addr;
      logic [ID_W-1:0] sm_data;
      logic es_we;
      logic [ID_W-1:0] es_addr;
      logic [SLOT_W-1:0] es_data;
      logic vl_we;
      logic [ID_W-1:0] vl_addr;
      logic vl_data;
   } msr_wr_type;

endpackage

/* hw/rtl/swap_remove_member_set_top.sv */
`timescale 1ns / 1ps

// Dense member set over element ids 0..63 with swap-remove. Ops: insert, remove
// by id, remove the member at a given slot. Throughput is one op per clock while
// the result register is free or being read out (tables are memories with a
// registered read issued on the request beat, the op resolves and writes back
// once the result register can take it, the result sits in an output register).
// Writes of the op ahead are bypassed into the reads of the next one. Membership
// marks are flip-flops cleared by reset at once, so no clearing pass is needed.
module swap_remove_member_set_top import msr_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,  // op[1:0], element_id[7:2], pick_slot[13:8]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata   // status[2:0], removed_id[8:3], assigned_slot[14:9],
                                   // member_count[21:15]
);

   logic req_beat;
   logic fire;
   msr_item_type req_item;

   logic s1_valid_ff, s1_valid_in;
   msr_item_type s1_item_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   msr_result_type rsp_ff;

   msr_wr_type wr_raw, wr;
   msr_result_type res;
   logic [CNT_W-1:0] count_next;
   logic [CNT_W-1:0] last_cnt;
   logic [ID_W-1:0] sm_pick, sm_last;
   logic [SLOT_W-1:0] es_id;
   logic valid_id;

   assign req_item.op         = req_tdata[1:0];
   assign req_item.element_id = req_tdata[7:2];
   assign req_item.pick_slot  = req_tdata[13:8];

   assign fire       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || fire;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      wr = wr_raw;
      wr.sm_we = wr_raw.sm_we && fire;
      wr.es_we = wr_raw.es_we && fire;
      wr.vl_we = wr_raw.vl_we && fire;
      count_in = fire ? count_next : count_ff;
      last_cnt = count_in - CNT_W'(1);
      s1_valid_in = req_beat ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   msr_tables u_tables (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_beat),
      .rd_pick    (req_item.pick_slot),
      .rd_last    (last_cnt[SLOT_W-1:0]),
      .rd_id      (req_item.element_id),
      .vl_rd_addr (s1_item_ff.element_id),
      .wr         (wr),
      .sm_pick    (sm_pick),
      .sm_last    (sm_last),
      .es_id      (es_id),
      .valid_id   (valid_id)
   );

   msr_exec u_exec (
      .item       (s1_item_ff),
      .count      (count_ff),
      .sm_pick    (sm_pick),
      .sm_last    (sm_last),
      .es_id      (es_id),
      .valid_id   (valid_id),
      .wr         (wr_raw),
      .res        (res),
      .count_next (count_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_item_ff <= req_item;
      end
      if (fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.member_count, rsp_ff.assigned_slot,
                        rsp_ff.removed_id, rsp_ff.status};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("member count above capacity");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      fire && res.status != ST_OK |=> $stable(count_ff))
      else $error("failed op changed member count");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      fire && res.status == ST_OK && s1_item_ff.op == OP_INSERT
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the set");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline stalled");
`endif

endmodule

/* hw/rtl/msr_tables.sv */
`timescale 1ns / 1ps

module msr_tables import msr_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic rd_en,
   input  logic [SLOT_W-1:0] rd_pick,
   input  logic [SLOT_W-1:0] rd_last,
   input  logic [ID_W-1:0] rd_id,
   input  logic [ID_W-1:0] vl_rd_addr,
   input  msr_wr_type wr,
   output logic [ID_W-1:0] sm_pick,
   output logic [ID_W-1:0] sm_last,
   output logic [SLOT_W-1:0] es_id,
   output logic valid_id
);

   logic [ID_W-1:0] slot_mem_ff [MAX_ELEMENTS];
   logic [SLOT_W-1:0] elem_mem_ff [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] valid_ff;

   logic [ID_W-1:0] sm_pick_rd_ff;
   logic [ID_W-1:0] sm_last_rd_ff;
   logic [SLOT_W-1:0] es_rd_ff;
   logic [SLOT_W-1:0] pick_addr_ff;
   logic [SLOT_W-1:0] last_addr_ff;
   logic [ID_W-1:0] id_addr_ff;
   msr_wr_type fwd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sm_pick_rd_ff <= slot_mem_ff[rd_pick];
         sm_last_rd_ff <= slot_mem_ff[rd_last];
         es_rd_ff      <= elem_mem_ff[rd_id];
         pick_addr_ff  <= rd_pick;
         last_addr_ff  <= rd_last;
         id_addr_ff    <= rd_id;
      end
      if (wr.sm_we) begin
         slot_mem_ff[wr.sm_addr] <= wr.sm_data;
      end
      if (wr.es_we) begin
         elem_mem_ff[wr.es_addr] <= wr.es_data;
      end
   end

   // write landing on the same edge as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff.sm_we <= 1'b0;
         fwd_ff.es_we <= 1'b0;
         fwd_ff.vl_we <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.vl_we) begin
         valid_ff[wr.vl_addr] <= wr.vl_data;
      end
   end

   always_comb begin
      sm_pick = (fwd_ff.sm_we && fwd_ff.sm_addr == pick_addr_ff) ? fwd_ff.sm_data
                                                                 : sm_pick_rd_ff;
      sm_last = (fwd_ff.sm_we && fwd_ff.sm_addr == last_addr_ff) ? fwd_ff.sm_data
                                                                 : sm_last_rd_ff;
      es_id   = (fwd_ff.es_we && fwd_ff.es_addr == id_addr_ff) ? fwd_ff.es_data
                                                               : es_rd_ff;
      valid_id = valid_ff[vl_rd_addr];
   end

endmodule

/* hw/rtl/msr_exec.sv */
`timescale 1ns / 1ps

module msr_exec import msr_pkg::*; (
   input  msr_item_type item,
   input  logic [CNT_W-1:0] count,
   input  logic [ID_W-1:0] sm_pick,
   input  logic [ID_W-1:0] sm_last,
   input  logic [SLOT_W-1:0] es_id,
   input  logic valid_id,
   output msr_wr_type wr,
   output msr_result_type res,
   output logic [CNT_W-1:0] count_next
);

   logic [CNT_W-1:0] count_dec;
   logic [SLOT_W-1:0] hole;
   logic do_remove;

   always_comb begin
      wr = '0;
      res = '0;
      res.status = ST_OK;
      count_next = count;
      count_dec = count - CNT_W'(1);
      hole = '0;
      do_remove = 1'b0;

      case (item.op)
         OP_INSERT: begin
            if (valid_id) begin
               res.status = ST_ALREADY;
            end else if (count >= CNT_W'(MAX_ELEMENTS)) begin
               res.status = ST_PICK_RANGE;
            end else begin
               wr.sm_we   = 1'b1;
               wr.sm_addr = count[SLOT_W-1:0];
               wr.sm_data = item.element_id;
               wr.es_we   = 1'b1;
               wr.es_addr = item.element_id;
               wr.es_data = count[SLOT_W-1:0];
               wr.vl_we   = 1'b1;
               wr.vl_addr = item.element_id;
               wr.vl_data = 1'b1;
               res.assigned_slot = count[SLOT_W-1:0];
               count_next = count + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (!valid_id) begin
               res.status = ST_NOT_MEMBER;
            end else begin
               do_remove = 1'b1;
               hole = es_id;
               wr.vl_addr = item.element_id;
            end
         end
         OP_REMOVE_AT: begin
            if (count == '0) begin
               res.status = ST_EMPTY;
            end else if ({1'b0, item.pick_slot} >= count) begin
               res.status = ST_PICK_RANGE;
            end else begin
               do_remove = 1'b1;
               hole = item.pick_slot;
               wr.vl_addr = sm_pick;
               res.removed_id = sm_pick;
            end
         end
         default: begin
         end
      endcase

      // last member fills the hole
      if (do_remove) begin
         wr.vl_we   = 1'b1;
         wr.vl_data = 1'b0;
         count_next = count_dec;
         if (count_dec != '0 && {1'b0, hole} != count_dec) begin
            wr.sm_we   = 1'b1;
            wr.sm_addr = hole;
            wr.sm_data = sm_last;
            wr.es_we   = 1'b1;
            wr.es_addr = sm_last;
            wr.es_data = hole;
         end
      end

      res.member_count = count_next;
   end

endmodule

/* verif/swap_remove_member_set_top_tb.sv */
`timescale 1ns / 1ps

module swap_remove_member_set_top_tb;
   import msr_pkg::*;

   localparam logic [OP_W-1:0] OP_NOP = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_OPS = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;  // op[1:0], element_id[7:2], pick_slot[13:8]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // status[2:0], removed_id[8:3], assigned_slot[14:9],
                                 // member_count[21:15]

   // set contents as seen by the op planner
   logic [ID_W-1:0] slot_owner [MAX_ELEMENTS];
   logic [SLOT_W-1:0] home_slot [MAX_ELEMENTS];
   logic is_member [MAX_ELEMENTS];
   logic [CNT_W-1:0] set_size = '0;

   // queues fill at the front and drain from the back
   msr_item_type pending_ops[$];
   msr_result_type pending_answers[$];
   msr_result_type awaited_answers[$];
   msr_item_type next_op;
   msr_result_type held_answer;
   msr_result_type oldest_answer;

   int send_idle_pct = 8;
   int recv_idle_pct = 50;
   int error_count = 0;
   int cycle_count = 0;

   swap_remove_member_set_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // drop a member; the last member moves into the freed slot
   function automatic void evict(input logic [ID_W-1:0] e);
      logic [SLOT_W-1:0] hole;
      logic [ID_W-1:0] moved;
      hole = home_slot[e];
      is_member[e] = 1'b0;
      home_slot[e] = '0;
      set_size = set_size - CNT_W'(1);
      if (set_size != '0 && {1'b0, hole} != set_size) begin
         moved = slot_owner[set_size[SLOT_W-1:0]];
         slot_owner[hole] = moved;
         home_slot[moved] = hole;
      end
   endfunction

   function automatic msr_result_type set_apply(input msr_item_type it);
      msr_result_type r;
      logic [ID_W-1:0] victim;
      r = '0;
      r.status = ST_OK;
      case (it.op)
         OP_INSERT: begin
            if (is_member[it.element_id]) begin
               r.status = ST_ALREADY;
            end else if (set_size >= CNT_W'(MAX_ELEMENTS)) begin
               r.status = ST_PICK_RANGE;
            end else begin
               slot_owner[set_size[SLOT_W-1:0]] = it.element_id;
               is_member[it.element_id] = 1'b1;
               home_slot[it.element_id] = set_size[SLOT_W-1:0];
               r.assigned_slot = set_size[SLOT_W-1:0];
               set_size = set_size + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (!is_member[it.element_id]) begin
               r.status = ST_NOT_MEMBER;
            end else begin
               evict(it.element_id);
            end
         end
         OP_REMOVE_AT: begin
            if (set_size == '0) begin
               r.status = ST_EMPTY;
            end else if ({1'b0, it.pick_slot} >= set_size) begin
               r.status = ST_PICK_RANGE;
            end else begin
               victim = slot_owner[it.pick_slot];
               r.removed_id = victim;
               evict(victim);
            end
         end
         default: begin
         end
      endcase
      r.member_count = set_size;
      return r;
   endfunction

   function automatic void queue_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                    input logic [SLOT_W-1:0] pick);
      msr_item_type it;
      it.op = op;
      it.element_id = id;
      it.pick_slot = pick;
      pending_ops.push_front(it);
      pending_answers.push_front(set_apply(it));
   endfunction

   // mostly ops that succeed, with a share of errors and ignored-field noise
   function automatic void queue_random_op();
      int roll;
      int ins_pct;
      logic [ID_W-1:0] id;
      logic [SLOT_W-1:0] pick;
      roll = $urandom_range(99);
      ins_pct = (set_size < CNT_W'(40)) ? 50 : 30;
      id = ID_W'($urandom_range(MAX_ELEMENTS - 1));
      pick = SLOT_W'($urandom_range(MAX_ELEMENTS - 1));
      if (roll < 5) begin
         queue_op(OP_NOP, id, pick);
      end else if (roll < 5 + ins_pct) begin
         if (set_size < CNT_W'(MAX_ELEMENTS) && $urandom_range(9) != 0) begin
            while (is_member[id]) id = ID_W'($urandom_range(MAX_ELEMENTS - 1));
         end
         queue_op(OP_INSERT, id, pick);
      end else if (roll < 75) begin
         if (set_size != '0 && $urandom_range(9) != 0) begin
            id = slot_owner[SLOT_W'($urandom_range(set_size - 1))];
         end
         queue_op(OP_REMOVE, id, pick);
      end else begin
         if (set_size != '0 && $urandom_range(7) != 0) begin
            pick = SLOT_W'($urandom_range(set_size - 1));
         end
         queue_op(OP_REMOVE_AT, id, pick);
      end
   endfunction

   task automatic wait_idle();
      while (pending_ops.size() != 0 || req_tvalid || awaited_answers.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic void check_field(input string label, input logic [7:0] want_v,
                                       input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %0d, got %0d", label, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) awaited_answers.push_front(held_answer);
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_op = pending_ops.pop_back();
               held_answer = pending_answers.pop_back();
               req_tdata <= {2'b00, next_op.pick_slot, next_op.element_id, next_op.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_answers.size() == 0) begin
               $error("result beat with nothing awaited: %h", rsp_tdata);
               error_count++;
            end else begin
               oldest_answer = awaited_answers.pop_back();
               check_field("status", 8'(oldest_answer.status), 8'(rsp_tdata[2:0]));
               check_field("removed_id", 8'(oldest_answer.removed_id),
                           8'(rsp_tdata[8:3]));
               check_field("assigned_slot", 8'(oldest_answer.assigned_slot),
                           8'(rsp_tdata[14:9]));
               check_field("member_count", 8'(oldest_answer.member_count),
                           8'(rsp_tdata[21:15]));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("swap_remove_member_set_top test failed");
         $finish;
      end
   end

   initial begin
      int order [MAX_ELEMENTS];
      int j;
      int tmp;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         is_member[ID_W'(i)] = 1'b0;
         home_slot[ID_W'(i)] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty set, unused op code, duplicates, picks out of range, last-slot moves
      queue_op(OP_REMOVE, 6'd0, 6'd63);
      queue_op(OP_REMOVE_AT, 6'd63, 6'd0);
      queue_op(OP_NOP, 6'd63, 6'd63);
      queue_op(OP_INSERT, 6'd0, 6'd42);
      queue_op(OP_INSERT, 6'd63, 6'd21);
      queue_op(OP_INSERT, 6'd63, 6'd0);
      queue_op(OP_INSERT, 6'd42, 6'd0);
      queue_op(OP_INSERT, 6'd21, 6'd63);
      queue_op(OP_REMOVE_AT, 6'd0, 6'd63);
      queue_op(OP_REMOVE_AT, 6'd0, 6'd4);
      queue_op(OP_REMOVE_AT, 6'd42, 6'd3);
      queue_op(OP_REMOVE_AT, 6'd21, 6'd0);
      queue_op(OP_REMOVE, 6'd0, 6'd42);
      queue_op(OP_INSERT, 6'd21, 6'd21);
      queue_op(OP_REMOVE, 6'd42, 6'd0);
      queue_op(OP_REMOVE, 6'd63, 6'd63);
      queue_op(OP_REMOVE, 6'd21, 6'd0);
      queue_op(OP_NOP, 6'd0, 6'd0);
      wait_idle();

      for (int i = 0; i < RANDOM_OPS; i++) queue_random_op();
      wait_idle();

      send_idle_pct = 50;
      recv_idle_pct = 8;
      for (int i = 0; i < RANDOM_OPS; i++) queue_random_op();
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // fill to capacity in random order
      for (int i = 0; i < MAX_ELEMENTS; i++) order[ID_W'(i)] = i;
      for (int i = MAX_ELEMENTS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[ID_W'(i)];
         order[ID_W'(i)] = order[ID_W'(j)];
         order[ID_W'(j)] = tmp;
      end
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         queue_op(OP_INSERT, ID_W'(order[ID_W'(i)]),
                  SLOT_W'($urandom_range(MAX_ELEMENTS - 1)));
      end
      queue_op(OP_INSERT, ID_W'($urandom_range(MAX_ELEMENTS - 1)), 6'd0);
      queue_op(OP_REMOVE_AT, 6'd0, 6'd63);
      for (int i = 0; i < 100; i++) queue_random_op();
      // drain by random picks
      while (set_size != '0) begin
         queue_op(OP_REMOVE_AT, ID_W'($urandom_range(MAX_ELEMENTS - 1)),
                  SLOT_W'($urandom_range(set_size - 1)));
      end
      queue_op(OP_REMOVE_AT, 6'd0, 6'd0);
      queue_op(OP_REMOVE, ID_W'($urandom_range(MAX_ELEMENTS - 1)), 6'd0);
      wait_idle();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("swap_remove_member_set_top test passed");
      end else begin
         $display("swap_remove_member_set_top test failed");
      end
      $finish;
   end

endmodule

/* swap_remove_member_set_top.f */
hw/rtl/msr_pkg.sv
hw/rtl/msr_tables.sv
hw/rtl/msr_exec.sv
hw/rtl/swap_remove_member_set_top.sv
verif/swap_remove_member_set_top_tb.sv
